/* hdl/elevator_dispatch_controller_core_defines.svh */
// ----------------------------------------------------------------------------
// elevator dispatch controller core - assertion macros
// shared check macros, clocked on clk and quiet while rst is high
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_DISPATCH_CONTROLLER_CORE_DEFINES_SVH
`define ELEVATOR_DISPATCH_CONTROLLER_CORE_DEFINES_SVH

// property that must hold at every edge out of reset
`define EDC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition at one edge implies a condition at the next edge
`define EDC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/edc_pkg.sv */
// ----------------------------------------------------------------------------
// edc_pkg
// widths, codes and link types shared by the elevator dispatch controller
// ----------------------------------------------------------------------------
`default_nettype none

package edc_pkg;

  localparam int NUM_FLOORS_DEFAULT = 16;
  localparam int CALL_W     = 16;
  localparam int FLOOR_W    = 5;
  localparam int IDLE_W     = 16;
  localparam int TIME_W     = 32;
  localparam int STEP_T_W   = 8;
  localparam int ACT_W      = 3;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 48;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

  localparam logic [ACT_W-1:0] ACT_WAIT      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STOP      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MOVE      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP_MOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_IDLE      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_FLOOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IDLE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_TIME  = 8'd3;

  // carried from a floor to the one above it
  typedef struct packed {
    logic nbr_car;
    logic car_below;
    logic above_sel;
    logic above_any;
  } edc_up_link_t;

  // carried from a floor to the one below it
  typedef struct packed {
    logic nbr_car;
    logic car_above;
    logic below_sel;
    logic below_any;
    logic here_up;
    logic here_dn;
    logic here_car;
    logic all_any;
  } edc_dn_link_t;

  // broadcast to every floor cell
  typedef struct packed {
    logic step;
    logic fit;
    logic clr_up;
    logic clr_dn;
    logic clr_car;
    logic move_up;
    logic move_dn;
  } edc_ctl_t;

  // per floor control
  typedef struct packed {
    logic served;
    logic fit_keep;
    logic fit_top;
    logic new_up;
    logic new_dn;
    logic new_car;
    logic set_car;
  } edc_cell_in_t;

endpackage

`default_nettype wire

/* hdl/elevator_dispatch_controller_core.sv */
// ----------------------------------------------------------------------------
// elevator_dispatch_controller_core
// collective scan dispatch, one control step per input beat
// ----------------------------------------------------------------------------
// s_tvalid/s_tready/s_tdata carry one control step with new hall-up,
// hall-down and car call masks. m_tvalid/m_tready/m_tdata return one
// result beat per step: action, departed and arrived floor, heading and
// the running time count. cfg_valid/cfg_ready/cfg_index/cfg_data write the
// four registers; cfg_ready is always high, writes beyond index 3 are
// dropped, and writes belong in idle periods.
// Each floor is a cell in a chain; calls above and below the car ripple
// through the chain so the whole decision settles combinationally.
// Each input beat's result is loaded into the output register as the beat
// is accepted. Throughput is one step per cycle; s_tready drops only while
// a result is held because m_tready is low, so a stalled receiver stalls
// the input side with no loss.
// Synchronous rst restores the register defaults, clears all calls,
// parks the car at floor one with no direction and zeroes the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_dispatch_controller_core #(
  parameter int NUM_FLOORS = edc_pkg::NUM_FLOORS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // new_up_calls[15:0], new_down_calls[31:16], new_car_calls[47:32]
  input  logic [edc_pkg::IN_W-1:0]        s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // action[2:0], departed_floor[7:3], arrived_floor[12:8], heading[14:13],
  // time_now[46:15], zero[47]
  output logic [edc_pkg::OUT_W-1:0]       m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [edc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [edc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FloorLimit = (NUM_FLOORS < edc_pkg::CALL_W) ? NUM_FLOORS : edc_pkg::CALL_W;
  localparam logic [edc_pkg::FLOOR_W-1:0] TopLimit = edc_pkg::FLOOR_W'(FloorLimit);
  localparam logic [edc_pkg::FLOOR_W-1:0] TopMin   = edc_pkg::FLOOR_W'(2);
  localparam logic [edc_pkg::FLOOR_W-1:0] HomeFloor = edc_pkg::FLOOR_W'(1);

  logic [edc_pkg::FLOOR_W-1:0]  eff_top;
  logic [edc_pkg::IDLE_W-1:0]   max_idle;
  logic [edc_pkg::STEP_T_W-1:0] stop_time;
  logic [edc_pkg::STEP_T_W-1:0] run_time;
  logic [edc_pkg::FLOOR_W-1:0]  car_floor, car_floor_next;
  logic [edc_pkg::DIR_W-1:0]    direction, direction_next;
  logic [edc_pkg::IDLE_W-1:0]   idle_count, idle_count_next;
  logic [edc_pkg::TIME_W-1:0]   elapsed, elapsed_next;
  logic [edc_pkg::ACT_W-1:0]    action;

  logic s_accept, cfg_write, fit;
  logic [edc_pkg::FLOOR_W-1:0] top_raw, top_new;

  edc_pkg::edc_ctl_t     ctl;
  edc_pkg::edc_cell_in_t ci [FloorLimit];
  edc_pkg::edc_up_link_t up_l [FloorLimit+1];
  edc_pkg::edc_dn_link_t dn_l [FloorLimit+1];
  logic [FloorLimit-1:0] car_bits;

  logic any_call, ret_home, idle, stop, moved;
  logic [edc_pkg::DIR_W-1:0] d0, nd;
  logic hu2, hd2, hc2, l_all, b_sel, stop_after;

  assign s_tready  = !m_tvalid || m_tready;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign fit       = cfg_write && (cfg_index == edc_pkg::REG_TOP_FLOOR);

  // clamp of a written top floor
  assign top_raw = cfg_data[edc_pkg::FLOOR_W-1:0];
  always_comb begin
    priority if (top_raw < TopMin) begin
      top_new = TopMin;
    end else if (top_raw > TopLimit) begin
      top_new = TopLimit;
    end else begin
      top_new = top_raw;
    end
  end

  // floor chain
  assign up_l[0]          = '0;
  assign dn_l[FloorLimit] = '0;

  for (genvar i = 0; i < FloorLimit; i++) begin : g_floor
    always_comb begin
      ci[i].served   = eff_top > edc_pkg::FLOOR_W'(i);
      ci[i].fit_keep = top_new > edc_pkg::FLOOR_W'(i);
      ci[i].fit_top  = top_new == edc_pkg::FLOOR_W'(i + 1);
      ci[i].new_up   = s_tdata[i];
      ci[i].new_dn   = s_tdata[edc_pkg::CALL_W + i];
      ci[i].new_car  = s_tdata[2 * edc_pkg::CALL_W + i];
      ci[i].set_car  = (i == 0) && ret_home;
    end

    edc_floor_cell #(
      .IS_HOME (i == 0)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .ci     (ci[i]),
      .up_in  (up_l[i]),
      .up_out (up_l[i+1]),
      .dn_in  (dn_l[i+1]),
      .dn_out (dn_l[i])
    );

    assign car_bits[i] = dn_l[i].nbr_car;
  end

  // step decision
  always_comb begin
    any_call = dn_l[0].all_any;
    ret_home = !any_call && (idle_count > max_idle) && (car_floor != HomeFloor);
    idle     = !any_call && !ret_home;
    d0       = any_call ? direction : edc_pkg::DIR_NONE;

    unique case (d0)
      edc_pkg::DIR_UP:   stop = dn_l[0].here_car | dn_l[0].here_up;
      edc_pkg::DIR_DOWN: stop = dn_l[0].here_car | dn_l[0].here_dn;
      default:           stop = dn_l[0].here_car | dn_l[0].here_up | dn_l[0].here_dn;
    endcase
    stop = stop && !idle;

    ctl.step    = s_accept;
    ctl.fit     = fit;
    ctl.clr_car = stop;
    ctl.clr_up  = stop && ((d0 == edc_pkg::DIR_UP) ||
                           ((d0 == edc_pkg::DIR_NONE) && dn_l[0].here_up));
    ctl.clr_dn  = stop && ((d0 == edc_pkg::DIR_DOWN) ||
                           ((d0 == edc_pkg::DIR_NONE) && !dn_l[0].here_up));

    hu2   = dn_l[0].here_up & ~ctl.clr_up;
    hd2   = dn_l[0].here_dn & ~ctl.clr_dn;
    hc2   = dn_l[0].here_car & ~ctl.clr_car;
    // home call sits below the car
    b_sel = dn_l[0].below_sel | ret_home;
    l_all = dn_l[0].below_any | ret_home | hu2 | hd2 | hc2;

    unique case (d0)
      edc_pkg::DIR_UP: begin
        priority if (up_l[FloorLimit].above_sel) nd = edc_pkg::DIR_UP;
        else if (b_sel)                          nd = edc_pkg::DIR_DOWN;
        else                                     nd = edc_pkg::DIR_NONE;
      end
      edc_pkg::DIR_DOWN: begin
        priority if (b_sel)                      nd = edc_pkg::DIR_DOWN;
        else if (up_l[FloorLimit].above_sel)     nd = edc_pkg::DIR_UP;
        else                                     nd = edc_pkg::DIR_NONE;
      end
      default: begin
        priority if (l_all)                      nd = edc_pkg::DIR_DOWN;
        else if (up_l[FloorLimit].above_any)     nd = edc_pkg::DIR_UP;
        else                                     nd = edc_pkg::DIR_NONE;
      end
    endcase

    unique case (nd)
      edc_pkg::DIR_UP:   stop_after = hc2 | hu2;
      edc_pkg::DIR_DOWN: stop_after = hc2 | hd2;
      default:           stop_after = 1'b1;
    endcase

    moved       = !idle && !stop_after;
    ctl.move_up = s_accept && moved && (nd == edc_pkg::DIR_UP);
    ctl.move_dn = s_accept && moved && (nd == edc_pkg::DIR_DOWN);

    priority if (ctl.move_up || (moved && (nd == edc_pkg::DIR_UP))) begin
      car_floor_next = car_floor + HomeFloor;
    end else if (moved) begin
      car_floor_next = car_floor - HomeFloor;
    end else begin
      car_floor_next = car_floor;
    end

    direction_next = idle ? edc_pkg::DIR_NONE : nd;

    priority if (idle) begin
      idle_count_next = (idle_count == '1) ? idle_count : idle_count + 1'b1;
    end else begin
      idle_count_next = '0;
    end

    elapsed_next = elapsed + edc_pkg::TIME_W'(idle)
                 + (stop  ? edc_pkg::TIME_W'(stop_time) : '0)
                 + (moved ? edc_pkg::TIME_W'(run_time)  : '0);

    priority if (idle)       action = edc_pkg::ACT_IDLE;
    else if (stop && moved)  action = edc_pkg::ACT_STOP_MOVE;
    else if (stop)           action = edc_pkg::ACT_STOP;
    else if (moved)          action = edc_pkg::ACT_MOVE;
    else                     action = edc_pkg::ACT_WAIT;
  end

  // registers and step state
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_top    <= TopLimit;
      max_idle   <= edc_pkg::IDLE_W'(10);
      stop_time  <= edc_pkg::STEP_T_W'(3);
      run_time   <= edc_pkg::STEP_T_W'(2);
      car_floor  <= HomeFloor;
      direction  <= edc_pkg::DIR_NONE;
      idle_count <= '0;
      elapsed    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        edc_pkg::REG_TOP_FLOOR: begin
          eff_top <= top_new;
          if (car_floor > top_new) begin
            car_floor <= top_new;
          end
        end
        edc_pkg::REG_MAX_IDLE:  max_idle  <= cfg_data;
        edc_pkg::REG_STOP_TIME: stop_time <= cfg_data[edc_pkg::STEP_T_W-1:0];
        edc_pkg::REG_RUN_TIME:  run_time  <= cfg_data[edc_pkg::STEP_T_W-1:0];
        default: ;
      endcase
    end else if (s_accept) begin
      car_floor  <= car_floor_next;
      direction  <= direction_next;
      idle_count <= idle_count_next;
      elapsed    <= elapsed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {1'b0, elapsed_next, direction_next, car_floor_next, car_floor, action};
    end
  end

`include "elevator_dispatch_controller_core_defines.svh"

  `EDC_CHECK(a_car_onehot, $onehot(car_bits), "car presence not one-hot across floors")
  `EDC_CHECK(a_car_range, (car_floor != '0) && (car_floor <= eff_top), "car floor out of range")
  `EDC_CHECK_NEXT(a_move_changes, s_accept && moved, car_floor != $past(car_floor),
                  "move beat left car in place")
  `EDC_CHECK_NEXT(a_idle_no_dir, s_accept && idle, direction == edc_pkg::DIR_NONE,
                  "idle beat kept a direction")

endmodule

`default_nettype wire

/* hdl/edc_floor_cell.sv */
// ----------------------------------------------------------------------------
// edc_floor_cell
// one floor: pending call bits and car presence, chained to its neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module edc_floor_cell #(
  parameter bit IS_HOME = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  edc_pkg::edc_ctl_t     ctl,
  input  edc_pkg::edc_cell_in_t ci,
  input  edc_pkg::edc_up_link_t up_in,
  output edc_pkg::edc_up_link_t up_out,
  input  edc_pkg::edc_dn_link_t dn_in,
  output edc_pkg::edc_dn_link_t dn_out
);

  logic pu, pd, pc, car_here;
  logic pu_m, pd_m, pc_m;
  logic sel_up, sel_dn, any_m;

  assign pu_m   = pu | (ci.new_up & ci.served);
  assign pd_m   = pd | (ci.new_dn & ci.served);
  assign pc_m   = pc | (ci.new_car & ci.served);
  assign sel_up = pc_m | pu_m;
  assign sel_dn = pc_m | pd_m;
  assign any_m  = pu_m | pd_m | pc_m;

  always_comb begin
    up_out.nbr_car   = car_here;
    up_out.car_below = up_in.car_below | car_here;
    up_out.above_sel = up_in.above_sel | (up_in.car_below & sel_up);
    up_out.above_any = up_in.above_any | (up_in.car_below & any_m);
  end

  always_comb begin
    dn_out.nbr_car   = car_here;
    dn_out.car_above = dn_in.car_above | car_here;
    dn_out.below_sel = dn_in.below_sel | (dn_in.car_above & sel_dn);
    dn_out.below_any = dn_in.below_any | (dn_in.car_above & any_m);
    dn_out.here_up   = dn_in.here_up | (car_here & pu_m);
    dn_out.here_dn   = dn_in.here_dn | (car_here & pd_m);
    dn_out.here_car  = dn_in.here_car | (car_here & pc_m);
    dn_out.all_any   = dn_in.all_any | any_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pu       <= 1'b0;
      pd       <= 1'b0;
      pc       <= 1'b0;
      car_here <= IS_HOME;
    end else if (ctl.fit) begin
      pu <= pu & ci.fit_keep;
      pd <= pd & ci.fit_keep;
      pc <= pc & ci.fit_keep;
      // car above the new top comes down to it
      car_here <= ci.fit_top ? (car_here | dn_in.car_above) : (car_here & ci.fit_keep);
    end else if (ctl.step) begin
      pu <= pu_m & ~(car_here & ctl.clr_up);
      pd <= pd_m & ~(car_here & ctl.clr_dn);
      pc <= (pc_m | ci.set_car) & ~(car_here & ctl.clr_car);
      priority if (ctl.move_up) begin
        car_here <= up_in.nbr_car;
      end else if (ctl.move_dn) begin
        car_here <= dn_in.nbr_car;
      end else begin
        car_here <= car_here;
      end
    end
  end

endmodule

`default_nettype wire

/* sim/elevator_dispatch_controller_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_dispatch_controller_core_tb
// self-checking bench for the collective scan dispatch core. A directed
// table walks reset, a stop with no direction, the idle return to floor
// one, a hall call at the car's own floor against the heading, calls above
// the top floor and the register extremes. Random call traffic follows
// under several register settings and three sender/receiver idling
// patterns. A model of the dispatch step predicts beats the table leaves open.
// ----------------------------------------------------------------------------
module elevator_dispatch_controller_core_tb;
  import edc_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int SUBPHASE_STEPS  = 45;
  localparam int MAX_SHOWN       = 30;
  localparam int HOLD_CYCLES     = 60;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [FLOOR_W-1:0] dep;
    logic [FLOOR_W-1:0] arr;
    logic [DIR_W-1:0]   hd;
    logic [TIME_W-1:0]  tm;
  } trip_t;

  typedef enum logic {ROW_STEP, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [CALL_W-1:0]     up;
    logic [CALL_W-1:0]     dn;
    logic [CALL_W-1:0]     car;
    logic                  chk;
    trip_t                 want;
  } dir_row_t;

  localparam trip_t NO_TRIP = '0;
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b1, '{ACT_IDLE, 5'd1, 5'd1, DIR_NONE, 32'd1}},
    '{ROW_STEP, '0, '0, 16'h1, 16'h1, 16'h1, 1'b1, '{ACT_STOP, 5'd1, 5'd1, DIR_DOWN, 32'd4}},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b1, '{ACT_STOP, 5'd1, 5'd1, DIR_NONE, 32'd7}},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h8000, 1'b1, '{ACT_MOVE, 5'd1, 5'd2, DIR_UP, 32'd9}},
    '{ROW_CFG, REG_TOP_FLOOR, 16'd3, '0, '0, '0, 1'b0, NO_TRIP},
    '{ROW_CFG, REG_MAX_IDLE, 16'd0, '0, '0, '0, 1'b0, NO_TRIP},
    '{ROW_STEP, '0, '0, 16'h0, 16'h2, 16'h0, 1'b1, '{ACT_WAIT, 5'd2, 5'd2, DIR_NONE, 32'd9}},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b1, '{ACT_STOP, 5'd2, 5'd2, DIR_NONE, 32'd12}},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b1, '{ACT_IDLE, 5'd2, 5'd2, DIR_NONE, 32'd13}},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b1, '{ACT_MOVE, 5'd2, 5'd1, DIR_DOWN, 32'd15}},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b1, '{ACT_STOP, 5'd1, 5'd1, DIR_NONE, 32'd18}},
    '{ROW_STEP, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_TRIP},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b0, NO_TRIP},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b0, NO_TRIP},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b0, NO_TRIP},
    '{ROW_CFG, REG_TOP_FLOOR, 16'hFFE0, '0, '0, '0, 1'b0, NO_TRIP},
    '{ROW_CFG, REG_UNUSED, 16'hFFFF, '0, '0, '0, 1'b0, NO_TRIP},
    '{ROW_CFG, REG_MAX_IDLE, 16'hFFFF, '0, '0, '0, 1'b0, NO_TRIP},
    '{ROW_CFG, REG_STOP_TIME, 16'hFFFF, '0, '0, '0, 1'b0, NO_TRIP},
    '{ROW_CFG, REG_RUN_TIME, 16'h00FF, '0, '0, '0, 1'b0, NO_TRIP},
    '{ROW_STEP, '0, '0, 16'hFFFF, 16'h0, 16'h0, 1'b0, NO_TRIP},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h8000, 1'b0, NO_TRIP},
    '{ROW_STEP, '0, '0, 16'h0, 16'h0, 16'h0, 1'b0, NO_TRIP},
    '{ROW_CFG, REG_TOP_FLOOR, 16'h001F, '0, '0, '0, 1'b0, NO_TRIP}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model of the car and its registers
  logic [FLOOR_W-1:0]  top_reg;
  logic [IDLE_W-1:0]   idle_lim;
  logic [STEP_T_W-1:0] stop_cost;
  logic [STEP_T_W-1:0] run_cost;
  logic [CALL_W-1:0]   calls_up;
  logic [CALL_W-1:0]   calls_dn;
  logic [CALL_W-1:0]   calls_car;
  logic [FLOOR_W-1:0]  car_at;
  logic [DIR_W-1:0]    heading_now;
  logic [IDLE_W-1:0]   idle_steps;
  logic [TIME_W-1:0]   clock_units;

  trip_t trips_due[$];
  int    trips_open = 0;
  int    mismatches = 0;
  int    steps_sent = 0;
  int    reg_writes = 0;
  int    act_seen[5] = '{0, 0, 0, 0, 0};
  int    snd_idle_pct = 7;
  int    rcv_idle_pct = 69;
  int    hold_req = 0;
  int    hold_left = 0;
  int    stuck = 0;

  elevator_dispatch_controller_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int served_top();
    int t;
    t = top_reg;
    if (t < 2) t = 2;
    if (t > CALL_W) t = CALL_W;
    return t;
  endfunction

  function automatic logic [CALL_W-1:0] floor_mask();
    logic [31:0] m;
    m = (32'd1 << served_top()) - 32'd1;
    return m[CALL_W-1:0];
  endfunction

  function automatic logic [CALL_W-1:0] stop_set(input logic [DIR_W-1:0] hd);
    if (hd == DIR_UP) return calls_car | calls_up;
    if (hd == DIR_DOWN) return calls_car | calls_dn;
    return calls_car | calls_up | calls_dn;
  endfunction

  function automatic logic [DIR_W-1:0] choose_heading(input logic [DIR_W-1:0] hd,
                                                      input int f);
    logic [31:0]       above;
    logic [31:0]       below;
    logic [CALL_W-1:0] all_calls;
    logic [DIR_W-1:0]  d;
    logic              go_up;
    logic              go_dn;
    int                low;
    above = {16'd0, floor_mask()} & ~((32'd1 << f) - 32'd1);
    below = (32'd1 << (f - 1)) - 32'd1;
    all_calls = stop_set(DIR_NONE);
    d = hd;
    if (d == DIR_NONE) begin
      if (all_calls != '0) begin
        low = 0;
        while (!all_calls[low]) low++;
        return (low + 1 > f) ? DIR_UP : DIR_DOWN;
      end
      d = DIR_UP;
    end
    go_up = (stop_set(DIR_UP) & above[CALL_W-1:0]) != '0;
    go_dn = (stop_set(DIR_DOWN) & below[CALL_W-1:0]) != '0;
    if (d == DIR_UP) begin
      if (go_up) return DIR_UP;
      if (go_dn) return DIR_DOWN;
    end else begin
      if (go_dn) return DIR_DOWN;
      if (go_up) return DIR_UP;
    end
    return DIR_NONE;
  endfunction

  function automatic trip_t dispatch_step(input logic [CALL_W-1:0] up_in,
                                          input logic [CALL_W-1:0] dn_in,
                                          input logic [CALL_W-1:0] car_in);
    logic [CALL_W-1:0] m;
    logic [CALL_W-1:0] here;
    logic              stopped;
    logic              moved;
    trip_t             r;
    m = floor_mask();
    r.dep = car_at;
    r.act = ACT_WAIT;
    stopped = 1'b0;
    moved = 1'b0;
    calls_up |= up_in & m;
    calls_dn |= dn_in & m;
    calls_car |= car_in & m;
    if ((calls_up | calls_dn | calls_car) == '0) begin
      heading_now = DIR_NONE;
      if (idle_steps > idle_lim && car_at != 5'd1) begin
        calls_car[0] = 1'b1;
        idle_steps = '0;
      end else begin
        if (idle_steps != '1) idle_steps++;
        clock_units += 1;
        r.act = ACT_IDLE;
      end
    end else begin
      idle_steps = '0;
    end
    if (r.act != ACT_IDLE) begin
      here = '0;
      here[car_at - 1] = 1'b1;
      if ((stop_set(heading_now) & here) != '0) begin
        calls_car &= ~here;
        if (heading_now == DIR_UP) calls_up &= ~here;
        else if (heading_now == DIR_DOWN) calls_dn &= ~here;
        else if ((calls_up & here) != '0) calls_up &= ~here;
        else calls_dn &= ~here;
        clock_units += stop_cost;
        stopped = 1'b1;
      end
      heading_now = choose_heading(heading_now, car_at);
      if (heading_now != DIR_NONE && (stop_set(heading_now) & here) == '0) begin
        if (heading_now == DIR_UP) car_at++;
        else car_at--;
        clock_units += run_cost;
        moved = 1'b1;
      end
      r.act = stopped ? (moved ? ACT_STOP_MOVE : ACT_STOP) : (moved ? ACT_MOVE : ACT_WAIT);
    end
    r.arr = car_at;
    r.hd = heading_now;
    r.tm = clock_units;
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    logic [CALL_W-1:0] m;
    case (idx)
      REG_TOP_FLOOR: begin
        top_reg = val[FLOOR_W-1:0];
        m = floor_mask();
        calls_up &= m;
        calls_dn &= m;
        calls_car &= m;
        if (car_at > served_top()) car_at = FLOOR_W'(served_top());
      end
      REG_MAX_IDLE:  idle_lim = val[IDLE_W-1:0];
      REG_STOP_TIME: stop_cost = val[STEP_T_W-1:0];
      REG_RUN_TIME:  run_cost = val[STEP_T_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch in %s at %0t: expected %0h, got %0h", what, $time, want, got);
  endtask

  task automatic check_trip(input logic [OUT_W-1:0] beat);
    trip_t want;
    if (trips_due.size() == 0) begin
      report_mismatch("beat with no step outstanding", '0, beat[31:0]);
      return;
    end
    want = trips_due.pop_front();
    trips_open--;
    if (beat[2:0] < 5) act_seen[beat[2:0]]++;
    if (beat[2:0] !== want.act) report_mismatch("action", want.act, beat[2:0]);
    if (beat[7:3] !== want.dep) report_mismatch("departed_floor", want.dep, beat[7:3]);
    if (beat[12:8] !== want.arr) report_mismatch("arrived_floor", want.arr, beat[12:8]);
    if (beat[14:13] !== want.hd) report_mismatch("heading", want.hd, beat[14:13]);
    if (beat[46:15] !== want.tm) report_mismatch("time_now", want.tm, beat[46:15]);
    if (beat[OUT_W-1] !== 1'b0) report_mismatch("pad bit", '0, beat[OUT_W-1]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    reg_writes++;
  endtask

  task automatic send_step(input logic [CALL_W-1:0] up_in, input logic [CALL_W-1:0] dn_in,
                           input logic [CALL_W-1:0] car_in, input logic typed,
                           input trip_t want);
    trip_t t;
    cfg_valid <= 1'b0;
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    t = dispatch_step(up_in, dn_in, car_in);
    trips_due.push_back(typed ? want : t);
    trips_open++;
    s_tvalid <= 1'b1;
    s_tdata <= {car_in, dn_in, up_in};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    steps_sent++;
  endtask

  // block is idle once every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    wait (trips_open == 0);
    repeat (2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_trip(m_tdata);
    if (hold_req != 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= WATCHDOG_CYCLES) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int                phase;
    int                sub;
    int                n;
    int                zeros;
    int                pick;
    int                b;
    logic [CALL_W-1:0] u;
    logic [CALL_W-1:0] d;
    logic [CALL_W-1:0] c;
    top_reg = 5'd16;
    idle_lim = 16'd10;
    stop_cost = 8'd3;
    run_cost = 8'd2;
    calls_up = '0;
    calls_dn = '0;
    calls_car = '0;
    car_at = 5'd1;
    heading_now = DIR_NONE;
    idle_steps = '0;
    clock_units = '0;
    zeros = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        if (i > 0 && DIR_TAB[i-1].kind == ROW_STEP) settle();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
      end else begin
        send_step(DIR_TAB[i].up, DIR_TAB[i].dn, DIR_TAB[i].car, DIR_TAB[i].chk,
                  DIR_TAB[i].want);
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 7;  rcv_idle_pct = 69; end
        1: begin snd_idle_pct = 69; rcv_idle_pct = 7;  end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (sub = 0; sub < 3; sub++) begin
        settle();
        case ($urandom_range(3))
          0: write_reg(REG_TOP_FLOOR, 16'd2);
          1: write_reg(REG_TOP_FLOOR, 16'd16);
          2: write_reg(REG_TOP_FLOOR, 16'($urandom_range(3, 8)));
          default: write_reg(REG_TOP_FLOOR, 16'($urandom_range(0, 65535)));
        endcase
        case ($urandom_range(3))
          0: write_reg(REG_MAX_IDLE, 16'd0);
          1: write_reg(REG_MAX_IDLE, 16'hFFFF);
          default: write_reg(REG_MAX_IDLE, 16'($urandom_range(1, 6)));
        endcase
        case ($urandom_range(3))
          0: write_reg(REG_STOP_TIME, 16'd0);
          1: write_reg(REG_STOP_TIME, 16'd255);
          default: write_reg(REG_STOP_TIME, 16'($urandom_range(0, 65535)));
        endcase
        case ($urandom_range(3))
          0: write_reg(REG_RUN_TIME, 16'd0);
          1: write_reg(REG_RUN_TIME, 16'd255);
          default: write_reg(REG_RUN_TIME, 16'($urandom_range(0, 65535)));
        endcase
        for (n = 0; n < SUBPHASE_STEPS; n++) begin
          // receiver stalls long enough to back up the input side
          if (phase == 2 && sub == 0 && n == 5) hold_req = 1;
          if (phase == 1 && sub == 1 && n == 20) settle();
          u = '0;
          d = '0;
          c = '0;
          if (zeros > 0) begin
            zeros--;
          end else begin
            pick = $urandom_range(99);
            if (pick < 8) begin
              // quiet spell so the idle count can run out
              zeros = $urandom_range(4, 14);
            end else if (pick < 30) begin
            end else if (pick < 75) begin
              b = ($urandom_range(9) == 0) ? $urandom_range(15)
                                           : $urandom_range(served_top() - 1);
              case ($urandom_range(2))
                0: u[b] = 1'b1;
                1: d[b] = 1'b1;
                default: c[b] = 1'b1;
              endcase
            end else if (pick < 93) begin
              u = 16'($urandom & $urandom);
              d = 16'($urandom & $urandom);
              c = 16'($urandom);
            end else begin
              u = '1;
              d = '1;
              c = '1;
            end
          end
          send_step(u, d, c, 1'b0, NO_TRIP);
        end
      end
    end

    settle();
    repeat (4) @(posedge clk);
    $display("covered %0d control steps and %0d register writes under three idling patterns",
             steps_sent, reg_writes);
    $display("actions: wait %0d, stop %0d, move %0d, stop+move %0d, idle %0d",
             act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
